[src/cwf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwf_pkg
// types and constants shared by the command watchdog failsafe fsm
// ----------------------------------------------------------------------------
package cwf_pkg;

    localparam int TIME_W   = 48;
    localparam int TMO_W    = 32;
    localparam int LIMIT_W  = 8;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [TMO_W-1:0]   LINEAR_TMO_RST  = 32'd500000000;
    localparam logic [TMO_W-1:0]   ANGULAR_TMO_RST = 32'd100000000;
    localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST  = 8'd100;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_TMO  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_TMO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_LIMIT  = 2'd2;

    // flight modes
    localparam logic [MODE_W-1:0] MODE_POSITION = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ATTITUDE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RATE     = 3'd4;

    typedef enum logic [1:0] {
        REQ_INIT    = 2'd0,
        REQ_SETMODE = 2'd1,
        REQ_COMMAND = 2'd2,
        REQ_TICK    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ACT_NONE      = 2'd0,
        ACT_HEARTBEAT = 2'd1,
        ACT_LOITER    = 2'd2,
        ACT_LAND      = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_INIT     = 4'd0,
        ST_READY    = 4'd1,
        ST_POSITION = 4'd2,
        ST_VELOCITY = 4'd3,
        ST_ACCEL    = 4'd4,
        ST_ATTITUDE = 4'd5,
        ST_RATE     = 4'd6,
        ST_TIMEOUT  = 4'd7,
        ST_HOLD     = 4'd8,
        ST_FAILSAFE = 4'd9,
        ST_LAND     = 4'd10
    } state_t;

    typedef struct packed {
        req_t                req_type;
        logic [MODE_W-1:0]   mode_sel;
        logic [TIME_W-1:0]   now_ns;
    } item_t;

    typedef struct packed {
        state_t               server_state;
        logic [MODE_W-1:0]    prior_mode;
        logic [TIME_W-1:0]    last_cmd_time;
        logic [LIMIT_W-1:0]   hold_count;
    } wdog_state_t;

    typedef struct packed {
        logic [TMO_W-1:0]     linear_tmo;
        logic [TMO_W-1:0]     angular_tmo;
        logic [LIMIT_W-1:0]   hold_limit;
    } cfg_t;

    typedef struct packed {
        logic                 accepted;
        action_t              action;
        logic [MODE_W-1:0]    heartbeat_mode;
        state_t               state_code;
    } result_t;

    // mode state code sits two above the mode number
    function automatic state_t mode_to_state(input logic [MODE_W-1:0] mode);
        return state_t'({1'b0, mode} + 4'd2);
    endfunction

    function automatic logic [MODE_W-1:0] state_to_mode(input state_t st);
        logic [3:0] diff;
        diff = st - 4'd2;
        return diff[MODE_W-1:0];
    endfunction

endpackage

[src/cwf_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwf_step
// next-state and result logic for one request of the watchdog
// ----------------------------------------------------------------------------
module cwf_step import cwf_pkg::*; (
    input  item_t       item,
    input  wdog_state_t cur,
    input  cfg_t        cfg,
    output wdog_state_t nxt,
    output result_t     res
);

    logic [TIME_W-1:0] elapsed;
    logic [MODE_W-1:0] cur_mode;
    logic [TMO_W-1:0]  cur_tmo;
    logic [TMO_W-1:0]  prior_tmo;
    logic              cur_stale;
    logic              prior_fresh;

    // wraps modulo 2^48
    assign elapsed   = item.now_ns - cur.last_cmd_time;
    assign cur_mode  = state_to_mode(cur.server_state);
    assign cur_tmo   = (cur_mode >= MODE_ATTITUDE) ? cfg.angular_tmo : cfg.linear_tmo;
    assign prior_tmo = (cur.prior_mode >= MODE_ATTITUDE) ? cfg.angular_tmo
                                                         : cfg.linear_tmo;
    assign cur_stale   = elapsed > {{(TIME_W-TMO_W){1'b0}}, cur_tmo};
    assign prior_fresh = elapsed < {{(TIME_W-TMO_W){1'b0}}, prior_tmo};

    always_comb begin
        nxt = cur;
        res = '0;
        res.action = ACT_NONE;
        if (item.req_type == REQ_INIT) begin
            if (cur.server_state == ST_INIT) begin
                nxt.server_state = ST_READY;
                res.accepted     = 1'b1;
            end
        end else if (cur.server_state != ST_INIT) begin
            unique case (item.req_type)
                REQ_SETMODE: begin
                    if (item.mode_sel <= MODE_RATE) begin
                        nxt.server_state  = mode_to_state(item.mode_sel);
                        nxt.last_cmd_time = item.now_ns;
                        res.accepted      = 1'b1;
                    end
                end
                REQ_COMMAND: begin
                    nxt.last_cmd_time = item.now_ns;
                    res.accepted      = 1'b1;
                end
                REQ_TICK: begin
                    res.accepted = 1'b1;
                    unique case (cur.server_state)
                        ST_POSITION: begin
                            res.action         = ACT_HEARTBEAT;
                            res.heartbeat_mode = MODE_POSITION;
                        end
                        ST_VELOCITY, ST_ACCEL, ST_ATTITUDE, ST_RATE: begin
                            if (cur_stale) begin
                                nxt.prior_mode   = cur_mode;
                                nxt.server_state = ST_TIMEOUT;
                            end else begin
                                res.action         = ACT_HEARTBEAT;
                                res.heartbeat_mode = cur_mode;
                            end
                        end
                        ST_TIMEOUT: begin
                            res.action       = ACT_LOITER;
                            nxt.hold_count   = '0;
                            nxt.server_state = ST_HOLD;
                        end
                        ST_HOLD: begin
                            nxt.hold_count = cur.hold_count + 8'd1;
                            if (cur.hold_count > cfg.hold_limit) begin
                                nxt.server_state = ST_FAILSAFE;
                            end else if (cur.prior_mode <= MODE_RATE && prior_fresh) begin
                                nxt.server_state = mode_to_state(cur.prior_mode);
                            end
                        end
                        ST_FAILSAFE: begin
                            res.action       = ACT_LAND;
                            nxt.server_state = ST_LAND;
                        end
                        default: begin
                            // ready and landed: tick does nothing
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        res.state_code = nxt.server_state;
    end

endmodule

[src/command_watchdog_failsafe_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_watchdog_failsafe_fsm
// watchdog over a command stream with loiter hold and failsafe landing
// ----------------------------------------------------------------------------
// usage
//   requests (init, set mode, command arrived, tick, each with the time in
//   ns) enter on the s_ valid/ready channel; one result per request leaves
//   on the m_ valid/ready channel, in order
//   configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 linear timeout, 1 angular timeout, 2 hold tick limit); other
//   indexes are ignored; write only while no request is in flight
//   stages: input register, then result register
//   throughput: one request per cycle while unstalled; the watchdog state
//   is read and written by the single step stage: each sees the last one
//   reset (aresetn low, synchronous): state to init, timers and counters
//   cleared, configuration to its defaults, both channels empty
//   stall: while m_ready is low the result register holds; the input
//   register still takes one request, then s_ready drops
// ----------------------------------------------------------------------------
module command_watchdog_failsafe_fsm import cwf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TMO_W-1:0]      cfg_wdata,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_req_type,
    input  logic [MODE_W-1:0]     s_mode_sel,
    input  logic [TIME_W-1:0]     s_now_ns,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_accepted,
    output logic [1:0]            m_action,
    output logic [MODE_W-1:0]     m_heartbeat_mode,
    output logic [3:0]            m_state_code
);

    // configuration registers
    cfg_t        cfg_reg;

    // input register stage
    logic        in_valid_reg;
    item_t       in_item_reg;

    // watchdog state
    wdog_state_t wd_reg;
    wdog_state_t wd_next;

    // result register stage
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     step_res;

    logic        advance;   // result slot free this cycle
    logic        fire;      // step stage commits a request

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.linear_tmo  <= LINEAR_TMO_RST;
            cfg_reg.angular_tmo <= ANGULAR_TMO_RST;
            cfg_reg.hold_limit  <= HOLD_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_LINEAR_TMO:  cfg_reg.linear_tmo  <= cfg_wdata;
                CFG_ANGULAR_TMO: cfg_reg.angular_tmo <= cfg_wdata;
                CFG_HOLD_LIMIT:  cfg_reg.hold_limit  <= cfg_wdata[LIMIT_W-1:0];
                default: begin
                    // index outside the register list
                end
            endcase
        end
    end

    // input register: payload loads whenever a request is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.req_type <= req_t'(s_req_type);
            in_item_reg.mode_sel <= s_mode_sel;
            in_item_reg.now_ns   <= s_now_ns;
        end
    end

    cwf_step u_step (
        .item (in_item_reg),
        .cur  (wd_reg),
        .cfg  (cfg_reg),
        .nxt  (wd_next),
        .res  (step_res)
    );

    // watchdog state commits together with the result load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wd_reg.server_state  <= ST_INIT;
            wd_reg.prior_mode    <= '0;
            wd_reg.last_cmd_time <= '0;
            wd_reg.hold_count    <= '0;
        end else if (fire) begin
            wd_reg <= wd_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= step_res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_accepted       = out_reg.accepted;
    assign m_action         = out_reg.action;
    assign m_heartbeat_mode = out_reg.heartbeat_mode;
    assign m_state_code     = out_reg.state_code;

endmodule
